[hw/rtl/rpvg_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// rpvg_pkg - regular polygon vertex generator package
// Shared widths, register indexes, limits and the constant tables used by
// the vertex sequencer and the CORDIC unit.
// ============================================================================
package rpvg_pkg;

    // Field widths
    localparam int COUNT_W  = 5;
    localparam int RADIUS_W = 10;
    localparam int COORD_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int INDEX_W  = 4;
    localparam int CFG_W    = 16;
    localparam int ADDR_W   = 2;

    // Register indexes
    localparam logic [ADDR_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [ADDR_W-1:0] REG_RADIUS       = 2'd1;
    localparam logic [ADDR_W-1:0] REG_CENTER_X     = 2'd2;
    localparam logic [ADDR_W-1:0] REG_CENTER_Y     = 2'd3;

    // Legal ranges; out-of-range writes store the minimum
    localparam int MIN_VERTICES = 3;
    localparam int MAX_VERTICES = 16;
    localparam int MIN_RADIUS   = 1;
    localparam int MAX_RADIUS   = 1023;

    // CORDIC datapath
    localparam int CORDIC_W     = 18;
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = 4;
    localparam int TRIG_W       = 16;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 18'sd9949;
    localparam logic signed [CORDIC_W-1:0] TRIG_ONE     = 18'sd16384;

    // Product of radius and Q1.14 trig value, plus rounding constant
    localparam int PROD_W = 26;
    localparam logic signed [PROD_W-1:0] PROD_ROUND = 26'sd8192;
    localparam int FRAC_BITS = 14;

    // Arctangent of 2^-k in units of 1/65536 turn
    function automatic logic signed [CORDIC_W-1:0] atan_step(input logic [STEP_W-1:0] k);
        logic signed [CORDIC_W-1:0] v;
        case (k)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    // Whole part of one vertex step, 65536 / n
    function automatic logic [ANGLE_W-1:0] step_quo(input logic [COUNT_W-1:0] n);
        logic [ANGLE_W-1:0] v;
        case (n)
            5'd3:    v = 16'd21845;
            5'd4:    v = 16'd16384;
            5'd5:    v = 16'd13107;
            5'd6:    v = 16'd10922;
            5'd7:    v = 16'd9362;
            5'd8:    v = 16'd8192;
            5'd9:    v = 16'd7281;
            5'd10:   v = 16'd6553;
            5'd11:   v = 16'd5957;
            5'd12:   v = 16'd5461;
            5'd13:   v = 16'd5041;
            5'd14:   v = 16'd4681;
            5'd15:   v = 16'd4369;
            5'd16:   v = 16'd4096;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Remainder of one vertex step, 65536 mod n
    function automatic logic [COUNT_W-1:0] step_rem(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] v;
        case (n)
            5'd3:    v = 5'd1;
            5'd5:    v = 5'd1;
            5'd6:    v = 5'd4;
            5'd7:    v = 5'd2;
            5'd9:    v = 5'd7;
            5'd10:   v = 5'd6;
            5'd11:   v = 5'd9;
            5'd12:   v = 5'd4;
            5'd13:   v = 5'd3;
            5'd14:   v = 5'd2;
            5'd15:   v = 5'd1;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/rpvg_cordic.sv]
`timescale 1ns / 1ps
// ============================================================================
// rpvg_cordic - iterative sine/cosine unit
// Folds a 16-bit turn angle into [-1/4, 1/4) turn, runs one CORDIC rotation
// per cycle through a shared pair of barrel shifters and adders, then
// unfolds and clamps the results to Q1.14.
// ============================================================================
module rpvg_cordic
    import rpvg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [ANGLE_W-1:0]       angle,
    output logic                     done,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROT,
        C_FIN
    } cordic_state_t;

    cordic_state_t               state_reg;
    logic signed [CORDIC_W-1:0]  x_reg, y_reg, z_reg;
    logic [STEP_W-1:0]           k_reg;
    logic                        flip_reg;
    logic signed [TRIG_W-1:0]    cos_reg, sin_reg;

    logic                        flip_in;
    logic [ANGLE_W-1:0]          folded;
    logic signed [CORDIC_W-1:0]  dx, dy, da;
    logic signed [CORDIC_W-1:0]  x_next, y_next, z_next;
    logic signed [CORDIC_W-1:0]  x_fin, y_fin;
    logic signed [CORDIC_W-1:0]  x_clamp, y_clamp;

    // Fold the angle by a half turn when it lies in the left half plane
    assign flip_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
    assign folded  = {angle[ANGLE_W-1] ^ flip_in, angle[ANGLE_W-2:0]};

    // One rotation step: floor shifts and add/subtract by the sign of z
    always_comb begin
        dx = y_reg >>> k_reg;
        dy = x_reg >>> k_reg;
        da = atan_step(k_reg);
        if (!z_reg[CORDIC_W-1]) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - da;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + da;
        end
    end

    // Unfold and clamp to [-1, 1] in Q1.14
    always_comb begin
        x_fin = flip_reg ? -x_reg : x_reg;
        y_fin = flip_reg ? -y_reg : y_reg;
        if (x_fin > TRIG_ONE)
            x_clamp = TRIG_ONE;
        else if (x_fin < -TRIG_ONE)
            x_clamp = -TRIG_ONE;
        else
            x_clamp = x_fin;
        if (y_fin > TRIG_ONE)
            y_clamp = TRIG_ONE;
        else if (y_fin < -TRIG_ONE)
            y_clamp = -TRIG_ONE;
        else
            y_clamp = y_fin;
    end

    // Sequence load, rotations and final clamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            k_reg     <= '0;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        x_reg     <= CORDIC_START;
                        y_reg     <= '0;
                        z_reg     <= CORDIC_W'(signed'(folded));
                        flip_reg  <= flip_in;
                        k_reg     <= '0;
                        state_reg <= C_ROT;
                    end
                end
                C_ROT: begin
                    x_reg <= x_next;
                    y_reg <= y_next;
                    z_reg <= z_next;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= C_FIN;
                end
                C_FIN: begin
                    cos_reg   <= x_clamp[TRIG_W-1:0];
                    sin_reg   <= y_clamp[TRIG_W-1:0];
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = (state_reg == C_FIN);
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

[hw/rtl/regular_polygon_vertex_generator_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// regular_polygon_vertex_generator_top - regular polygon vertex generator
// Per request beat, emits one vertex beat per polygon corner: center plus
// radius times (cos, sin) of the corner angle plus the requested offset.
//
//   Channel  Dir  Payload (low bit first)                       Handshake
//   s_       in   tdata: angle_offset[15:0]                       tvalid/tready
//   m_       out  tdata: vertex_x, vertex_y, vertex_index, pad    tvalid/tready
//                 tlast: last_vertex
//   cfg_     in   cfg_addr selects vertex_count/radius/center_x/y cfg_we
//
// Each vertex runs through these steps in order: launch; 14 CORDIC rotations
// plus 1 clamp in the shared rotation unit; radius times cos, then radius
// times sin on the shared multiplier, with x placed beside the second; place y;
// output. A stall on m_tready holds the current vertex beat and the sequencer.
// aresetn is synchronous and active low; it restores the register defaults.
// ============================================================================
module regular_polygon_vertex_generator_top
    import rpvg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write port
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // Request stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] angle_offset
    // Vertex stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // [15:0] vertex_x, [31:16] vertex_y,
                                         // [35:32] vertex_index, [39:36] zero
    output logic              m_tlast    // last_vertex
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_TRIG,
        S_MUL_X,
        S_MUL_Y,
        S_PLACE_Y,
        S_OUT
    } seq_state_t;

    // Configuration registers
    logic [COUNT_W-1:0]          vcount_reg;
    logic [RADIUS_W-1:0]         radius_reg;
    logic signed [COORD_W-1:0]   center_x_reg, center_y_reg;

    // Sequencer
    seq_state_t                  state_reg;
    logic [ANGLE_W-1:0]          offset_reg;
    logic [INDEX_W-1:0]          idx_reg;
    logic [ANGLE_W-1:0]          q_reg;
    logic [COUNT_W-1:0]          r_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [COORD_W-1:0]   vx_reg, vy_reg;

    logic [COUNT_W-1:0]          cfg_count;
    logic [RADIUS_W-1:0]         cfg_radius;
    logic                        trig_start;
    logic                        trig_done;
    logic signed [TRIG_W-1:0]    trig_cos, trig_sin;
    logic signed [TRIG_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    rounded;
    logic signed [COORD_W:0]     sum;
    logic signed [COORD_W-1:0]   place_sat;
    logic signed [COORD_W-1:0]   place_center;
    logic [COUNT_W-1:0]          r_sum;
    logic                        r_wrap;
    logic [ANGLE_W-1:0]          q_next;
    logic [COUNT_W-1:0]          r_next;
    logic                        is_last;

    // Substitute the minimum for out-of-range count and radius writes
    always_comb begin
        cfg_count  = cfg_wdata[COUNT_W-1:0];
        cfg_radius = cfg_wdata[RADIUS_W-1:0];
        if (!(cfg_count inside {[MIN_VERTICES:MAX_VERTICES]}))
            cfg_count = COUNT_W'(MIN_VERTICES);
        if (!(cfg_radius inside {[MIN_RADIUS:MAX_RADIUS]}))
            cfg_radius = RADIUS_W'(MIN_RADIUS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg   <= COUNT_W'(MIN_VERTICES);
            radius_reg   <= RADIUS_W'(MIN_RADIUS);
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_VERTEX_COUNT: vcount_reg   <= cfg_count;
                REG_RADIUS:       radius_reg   <= cfg_radius;
                REG_CENTER_X:     center_x_reg <= signed'(cfg_wdata[COORD_W-1:0]);
                REG_CENTER_Y:     center_y_reg <= signed'(cfg_wdata[COORD_W-1:0]);
                default: ;
            endcase
        end
    end

    // Shared sine/cosine unit
    assign trig_start = (state_reg == S_LAUNCH);

    rpvg_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (q_reg + offset_reg),
        .done    (trig_done),
        .cos_out (trig_cos),
        .sin_out (trig_sin)
    );

    // Shared multiplier: radius times cos, then radius times sin
    assign mul_b     = (state_reg == S_MUL_X) ? trig_cos : trig_sin;
    assign prod_next = PROD_W'(signed'({1'b0, radius_reg})) * PROD_W'(mul_b);

    // Round the product to a signed integer (Q16.0), add the center and saturate
    assign place_center = (state_reg == S_MUL_Y) ? center_x_reg : center_y_reg;
    always_comb begin
        rounded = (prod_reg + PROD_ROUND) >>> FRAC_BITS;
        sum     = (COORD_W+1)'(place_center) + (COORD_W+1)'(rounded);
        if (sum > (COORD_W+1)'(signed'({1'b0, {(COORD_W-1){1'b1}}})))
            place_sat = {1'b0, {(COORD_W-1){1'b1}}};
        else if (sum < (COORD_W+1)'(signed'({1'b1, {(COORD_W-1){1'b0}}})))
            place_sat = {1'b1, {(COORD_W-1){1'b0}}};
        else
            place_sat = sum[COORD_W-1:0];
    end

    // Advance the rounded vertex angle: whole step plus carried remainder
    always_comb begin
        r_sum  = r_reg + step_rem(vcount_reg);
        r_wrap = (r_sum >= vcount_reg);
        r_next = r_wrap ? r_sum - vcount_reg : r_sum;
        q_next = q_reg + step_quo(vcount_reg) + ANGLE_W'(r_wrap);
    end

    assign is_last = (idx_reg == INDEX_W'(vcount_reg - 1'b1));

    // Vertex sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        offset_reg <= s_tdata;
                        idx_reg    <= '0;
                        q_reg      <= '0;
                        r_reg      <= vcount_reg >> 1;
                        state_reg  <= S_LAUNCH;
                    end
                end
                S_LAUNCH: state_reg <= S_TRIG;
                S_TRIG: begin
                    if (trig_done)
                        state_reg <= S_MUL_X;
                end
                S_MUL_X: begin
                    prod_reg  <= prod_next;
                    state_reg <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    vx_reg    <= place_sat;
                    prod_reg  <= prod_next;
                    state_reg <= S_PLACE_Y;
                end
                S_PLACE_Y: begin
                    vy_reg    <= place_sat;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        if (is_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            q_reg     <= q_next;
                            r_reg     <= r_next;
                            state_reg <= S_LAUNCH;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'b0000, idx_reg, vy_reg, vx_reg};
    assign m_tlast  = is_last;

endmodule
